### design/rfsr_pkg.sv
package rfsr_pkg;

  // Ring geometry
  localparam int RingBits = 8;
  localparam int OnesW    = $clog2(RingBits + 1);

  // Fixed point voltages, 1 V = 1024
  localparam int VoltW  = 15;
  localparam int CvW    = 16;
  localparam int SumW   = 17;
  localparam int LevelW = 14;
  localparam int CountW = 17;
  localparam int BinW   = 15;

  localparam logic signed [SumW-1:0] VmaxWide  = 17'sd10240;
  localparam logic [LevelW-1:0]      LevelMax  = 14'd10240;
  localparam logic [CountW-1:0]      OnesStep  = 17'd1311;
  localparam logic [BinW-1:0]        BinTop    = 15'd5120;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgChangeLevel  = 3'd0,
    CfgChanceLevel  = 3'd1,
    CfgRateInc      = 3'd2,
    CfgInvertSwitch = 3'd3,
    CfgTriggerHigh  = 3'd4,
    CfgTriggerLow   = 3'd5
  } cfg_idx_e;

  localparam logic signed [VoltW-1:0] ChangeLevelRst = -15'sd10240;
  localparam logic signed [VoltW-1:0] ChanceLevelRst = -15'sd10240;
  localparam logic [31:0]             RateIncRst     = 32'd97391;
  localparam logic signed [VoltW-1:0] TriggerHighRst = 15'sd1024;
  localparam logic signed [VoltW-1:0] TriggerLowRst  = 15'sd0;

  typedef struct packed {
    logic signed [VoltW-1:0] noise_sample;
    logic signed [CvW-1:0]   change_cv;
    logic signed [CvW-1:0]   chance_cv;
    logic signed [CvW-1:0]   ext_chance_value;
    logic                    ext_chance_connected;
    logic signed [CvW-1:0]   ext_clock_value;
    logic                    ext_clock_connected;
    logic                    invert_cv_active;
  } in_item_t;

  typedef struct packed {
    logic [7:0]              ring_bits;
    logic                    stepped;
    logic [LevelW-1:0]       count_level;
    logic [LevelW-1:0]       binary_level;
    logic signed [VoltW-1:0] noise_out;
  } out_item_t;

  typedef struct packed {
    logic [LevelW-1:0] count_level;
    logic [LevelW-1:0] binary_level;
  } dac_level_t;

  // Clamp a widened voltage to +-10 V
  function automatic logic signed [VoltW-1:0] clamp_v(input logic signed [SumW-1:0] v);
    logic signed [VoltW-1:0] r;
    if (v > VmaxWide) begin
      r = VoltW'(VmaxWide);
    end else if (v < -VmaxWide) begin
      r = VoltW'(-VmaxWide);
    end else begin
      r = v[VoltW-1:0];
    end
    return r;
  endfunction

endpackage

### design/rfsr_if.sv
interface rfsr_in_if;
  logic                 valid;
  logic                 ready;
  rfsr_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rfsr_out_if;
  logic                 valid;
  logic                 ready;
  rfsr_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rfsr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rfsr_pkg::CfgIdxW-1:0]      index;
  logic [rfsr_pkg::CfgDataW-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/rfsr_dac.sv
module rfsr_dac (
  input  logic [rfsr_pkg::RingBits-1:0] ring_i,
  output rfsr_pkg::dac_level_t          level_o
);

  logic [rfsr_pkg::OnesW-1:0]  ones;
  logic [rfsr_pkg::BinW-1:0]   bin_sum;
  logic [rfsr_pkg::CountW-1:0] count_full;

  always_comb begin
    ones    = '0;
    bin_sum = '0;
    for (int i = 0; i < rfsr_pkg::RingBits; i++) begin
      if (ring_i[i]) begin
        ones    = ones + 1'b1;
        bin_sum = bin_sum + (rfsr_pkg::BinTop >> i);
      end
    end
  end

  assign count_full = rfsr_pkg::CountW'(ones) * rfsr_pkg::OnesStep;

  always_comb begin
    if (count_full > rfsr_pkg::CountW'(rfsr_pkg::LevelMax)) begin
      level_o.count_level = rfsr_pkg::LevelMax;
    end else begin
      level_o.count_level = count_full[rfsr_pkg::LevelW-1:0];
    end
    if (bin_sum > rfsr_pkg::BinW'(rfsr_pkg::LevelMax)) begin
      level_o.binary_level = rfsr_pkg::LevelMax;
    end else begin
      level_o.binary_level = bin_sum[rfsr_pkg::LevelW-1:0];
    end
  end

endmodule

### design/random_feedback_shift_ring.sv
// Random looping shift ring. Each input beat is one sample tick and yields exactly one
// result beat holding the ring after that tick, a step flag, the two DAC levels and the
// clamped noise. The ring steps on a rising edge of the external clock (Schmitt trigger)
// when ext_clock_connected is set, otherwise on a carry out of a 32-bit phase accumulator
// advanced by rate_increment each tick. Voltages are fixed point with 1 V = 1024. The
// block takes one beat per clock while the output is not stalled: a beat is held in an
// input register, its tick is evaluated in one pass against the ring, phase and trigger
// state, and the result lands in the output register. Configuration writes
// are always accepted and should only be issued while no beat is in flight.
module random_feedback_shift_ring (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfsr_cfg_if.sink    cfg_i,
  rfsr_in_if.sink     in_i,
  rfsr_out_if.source  out_o
);

  typedef enum logic [1:0] {
    TrigUnknown = 2'd0,
    TrigLow     = 2'd1,
    TrigHigh    = 2'd2
  } trig_e;

  localparam int SumW  = rfsr_pkg::SumW;
  localparam int VoltW = rfsr_pkg::VoltW;
  localparam int RB    = rfsr_pkg::RingBits;

  // config registers
  logic signed [VoltW-1:0] change_level_q, chance_level_q, trig_high_q, trig_low_q;
  logic [31:0]             rate_inc_q;
  logic                    invert_sw_q;

  // pipeline and state
  logic                s1_valid_q, out_valid_q;
  rfsr_pkg::in_item_t  s1_q;
  rfsr_pkg::out_item_t out_q, out_d;
  logic [RB-1:0]       ring_q, ring_d;
  logic [31:0]         phase_q, phase_d;
  trig_e               trig_q, trig_d;

  logic                    adv;
  logic signed [VoltW-1:0] noise, change, chance;
  logic signed [SumW-1:0]  change_sum, chance_sum, clk_v, th_hi, th_lo;
  logic signed [VoltW:0]   sample;
  logic [32:0]             phase_sum;
  logic                    sch_step, step, take_new, new_bit, old_bit, invert, fb_bit;
  rfsr_pkg::dac_level_t    level;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      change_level_q <= rfsr_pkg::ChangeLevelRst;
      chance_level_q <= rfsr_pkg::ChanceLevelRst;
      rate_inc_q     <= rfsr_pkg::RateIncRst;
      invert_sw_q    <= 1'b0;
      trig_high_q    <= rfsr_pkg::TriggerHighRst;
      trig_low_q     <= rfsr_pkg::TriggerLowRst;
    end else if (cfg_i.valid) begin
      case (rfsr_pkg::cfg_idx_e'(cfg_i.index))
        rfsr_pkg::CfgChangeLevel:  change_level_q <= cfg_i.data[VoltW-1:0];
        rfsr_pkg::CfgChanceLevel:  chance_level_q <= cfg_i.data[VoltW-1:0];
        rfsr_pkg::CfgRateInc:      rate_inc_q     <= cfg_i.data[31:0];
        rfsr_pkg::CfgInvertSwitch: invert_sw_q    <= cfg_i.data[0];
        rfsr_pkg::CfgTriggerHigh:  trig_high_q    <= cfg_i.data[VoltW-1:0];
        rfsr_pkg::CfgTriggerLow:   trig_low_q     <= cfg_i.data[VoltW-1:0];
        default: ;
      endcase
    end
  end

  // handshake: s1 moves into the output register when that slot frees up
  assign adv         = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || adv;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // voltage conditioning
  always_comb begin
    noise      = rfsr_pkg::clamp_v({{2{s1_q.noise_sample[VoltW-1]}}, s1_q.noise_sample});
    change_sum = {{2{change_level_q[VoltW-1]}}, change_level_q}
               + {s1_q.change_cv[15], s1_q.change_cv};
    chance_sum = {{2{chance_level_q[VoltW-1]}}, chance_level_q}
               + {s1_q.chance_cv[15], s1_q.chance_cv};
    change     = rfsr_pkg::clamp_v(change_sum);
    chance     = rfsr_pkg::clamp_v(chance_sum);
    sample     = s1_q.ext_chance_connected ? s1_q.ext_chance_value
                                           : {noise[VoltW-1], noise};
    clk_v      = {s1_q.ext_clock_value[15], s1_q.ext_clock_value};
    th_hi      = {{2{trig_high_q[VoltW-1]}}, trig_high_q};
    th_lo      = {{2{trig_low_q[VoltW-1]}}, trig_low_q};
  end

  // clock source: Schmitt trigger or phase accumulator
  always_comb begin
    trig_d    = trig_q;
    sch_step  = 1'b0;
    case (trig_q)
      TrigLow: begin
        if (clk_v >= th_hi) begin
          trig_d   = TrigHigh;
          sch_step = 1'b1;
        end
      end
      TrigHigh: begin
        if (clk_v <= th_lo) trig_d = TrigLow;
      end
      default: begin
        if (clk_v >= th_hi) trig_d = TrigHigh;
        else if (clk_v <= th_lo) trig_d = TrigLow;
      end
    endcase

    phase_sum = {1'b0, phase_q} + {1'b0, rate_inc_q};
    if (s1_q.ext_clock_connected) begin
      step    = sch_step;
      phase_d = sch_step ? '0 : phase_q;
    end else begin
      trig_d  = trig_q;
      step    = phase_sum[32];
      phase_d = phase_sum[32] ? '0 : phase_sum[31:0];
    end
  end

  // feedback bit selection
  always_comb begin
    take_new = noise > change;
    new_bit  = !($signed({sample[VoltW], sample}) > $signed({{2{chance[VoltW-1]}}, chance}));
    old_bit  = ring_q[RB-1];
    invert   = invert_sw_q || s1_q.invert_cv_active;
    if (invert) begin
      old_bit = ~old_bit;
    end else if (ring_q == '0) begin
      // stale all-zero ring: force a one in
      take_new = 1'b1;
      new_bit  = 1'b1;
    end else if (&ring_q) begin
      take_new = 1'b1;
      new_bit  = 1'b0;
    end
    fb_bit = take_new ? new_bit : old_bit;
    ring_d = step ? {ring_q[RB-2:0], fb_bit} : ring_q;
  end

  rfsr_dac u_dac (
    .ring_i  (ring_d),
    .level_o (level)
  );

  always_comb begin
    out_d.ring_bits    = 8'(ring_d);
    out_d.stepped      = step;
    out_d.count_level  = level.count_level;
    out_d.binary_level = level.binary_level;
    out_d.noise_out    = noise;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ring_q      <= '0;
      phase_q     <= '0;
      trig_q      <= TrigUnknown;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
        if (in_i.valid) s1_q <= in_i.data;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
        ring_q      <= ring_d;
        phase_q     <= phase_d;
        trig_q      <= trig_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_out_matches_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_q.ring_bits == 8'(ring_q))
    else $error("result beat ring differs from ring state");

  a_step_shifts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && step) |=> ring_q[RB-1:1] == $past(ring_q[RB-2:0]))
    else $error("ring did not shift on step");

  a_phase_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && step) |=> phase_q == '0)
    else $error("phase not cleared after step");

  a_trig_rise_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && trig_q == TrigLow && trig_d == TrigHigh) |-> step)
    else $error("trigger rise without a step");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ring_q == $past(ring_q) && phase_q == $past(phase_q))
    else $error("state moved without a beat");

endmodule
